>>> sv/cfsp_pkg.sv
`default_nettype none
package cfsp_pkg;
	typedef enum logic [5:0] {
		K_MAGIC = 6'd0, K_MINOR = 6'd1, K_MAJOR = 6'd2, K_CPCOUNT = 6'd3, K_TAG = 6'd4,
		K_UTF8_LEN = 6'd5, K_UTF8_BYTE = 6'd6, K_INTEGER = 6'd7, K_FLOAT = 6'd8,
		K_LONG_HI = 6'd9, K_LONG_LO = 6'd10, K_DOUBLE_HI = 6'd11, K_DOUBLE_LO = 6'd12,
		K_CLASS_NAME = 6'd13, K_STRING = 6'd14, K_REF_CLASS = 6'd15, K_REF_NAT = 6'd16,
		K_NAT_NAME = 6'd17, K_NAT_DESC = 6'd18, K_MH_KIND = 6'd19, K_MH_INDEX = 6'd20,
		K_MT_DESC = 6'd21, K_INDY_BS = 6'd22, K_INDY_NAT = 6'd23, K_MODULE = 6'd24,
		K_PACKAGE = 6'd25, K_ACCESS = 6'd26, K_THIS = 6'd27, K_SUPER = 6'd28,
		K_IF_COUNT = 6'd29, K_INTERFACE = 6'd30, K_FIELDS_COUNT = 6'd31,
		K_F_ACCESS = 6'd32, K_F_NAME = 6'd33, K_F_DESC = 6'd34, K_F_ACOUNT = 6'd35,
		K_METHODS_COUNT = 6'd36, K_M_ACCESS = 6'd37, K_M_NAME = 6'd38,
		K_M_DESC = 6'd39, K_M_ACOUNT = 6'd40, K_CLASS_ACOUNT = 6'd41,
		K_ATTR_NAME = 6'd42, K_ATTR_LEN = 6'd43, K_ATTR_BYTE = 6'd44
	} kind_t;

	typedef enum logic [1:0] {OWN_FIELD = 2'd0, OWN_METHOD = 2'd1, OWN_CLASS = 2'd2} owner_t;

	// constant pool tags
	localparam logic [7:0] TAG_UTF8 = 8'd1, TAG_INTEGER = 8'd3, TAG_FLOAT = 8'd4;
	localparam logic [7:0] TAG_LONG = 8'd5, TAG_DOUBLE = 8'd6, TAG_CLASS = 8'd7;
	localparam logic [7:0] TAG_STRING = 8'd8, TAG_FIELDREF = 8'd9, TAG_METHODREF = 8'd10;
	localparam logic [7:0] TAG_IFMETHODREF = 8'd11, TAG_NAT = 8'd12, TAG_MHANDLE = 8'd15;
	localparam logic [7:0] TAG_MTYPE = 8'd16, TAG_INDY = 8'd18, TAG_MODULE = 8'd19;
	localparam logic [7:0] TAG_PACKAGE = 8'd20;

	localparam int QDEPTH = 2;
	localparam int QAW = 1;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [7:0]  tag;
		logic [15:0] entry;
		logic [15:0] attr;
		logic        err;
		logic        done;
	} res_t;

	function automatic logic [2:0] kind_width(input kind_t k);
		case (k)
			K_MAGIC, K_INTEGER, K_FLOAT, K_LONG_HI, K_LONG_LO, K_DOUBLE_HI,
			K_DOUBLE_LO, K_ATTR_LEN: kind_width = 3'd4;
			K_TAG, K_UTF8_BYTE, K_MH_KIND, K_ATTR_BYTE: kind_width = 3'd1;
			default: kind_width = 3'd2;
		endcase
	endfunction
endpackage
`default_nettype wire

>>> sv/cfsp_front.sv
`default_nettype none
// Assembles bytes into fields and walks the file structure; emits one result per field.
module cfsp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	output logic               q_push,
	output cfsp_pkg::res_t     q_data,
	input  wire logic          q_full
);
	cfsp_pkg::kind_t  phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [23:0] asm_q, asm_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] pidx_q, pidx_d, ptot_q, ptot_d, oidx_q, oidx_d, otot_q, otot_d;
	logic [15:0] aidx_q, aidx_d, atot_q, atot_d;
	logic [31:0] left_q, left_d;
	logic        stop_q, stop_d;
	cfsp_pkg::owner_t own_q, own_d;

	logic [31:0] val;
	logic        fire, complete, done;
	logic [16:0] pnext;
	logic [15:0] onext, anext;
	logic [31:0] lm1;

	assign in_ready = ~q_full;
	assign fire = in_valid & in_ready & ~stop_q;
	assign val = {asm_q, in_byte};
	assign lm1 = left_q - 32'd1;
	assign onext = oidx_q + 16'd1;
	assign anext = aidx_q + 16'd1;

	always_comb begin
		phase_d = phase_q; cnt_d = cnt_q; asm_d = asm_q; tag_d = tag_q;
		pidx_d = pidx_q; ptot_d = ptot_q; oidx_d = oidx_q; otot_d = otot_q;
		aidx_d = aidx_q; atot_d = atot_q; left_d = left_q; stop_d = stop_q; own_d = own_q;
		done = 1'b0;
		pnext = {1'b0, pidx_q} + 17'd1;
		q_data = '0;
		complete = (cnt_q + 3'd1) >= cfsp_pkg::kind_width(phase_q);
		q_push = fire & complete;
		q_data.kind = phase_q;
		q_data.value = val;
		if (fire) begin
			if (!complete) begin
				asm_d = val[23:0];
				cnt_d = cnt_q + 3'd1;
			end else begin
				asm_d = '0;
				cnt_d = '0;
				if (phase_q inside {[cfsp_pkg::K_TAG:cfsp_pkg::K_PACKAGE]}) begin
					q_data.tag = (phase_q == cfsp_pkg::K_TAG) ? in_byte : tag_q;
					q_data.entry = pidx_q;
				end else if (phase_q == cfsp_pkg::K_INTERFACE ||
					phase_q inside {[cfsp_pkg::K_F_ACCESS:cfsp_pkg::K_F_ACOUNT],
					[cfsp_pkg::K_M_ACCESS:cfsp_pkg::K_M_ACOUNT]}) begin
					q_data.entry = oidx_q;
				end else if (phase_q >= cfsp_pkg::K_ATTR_NAME) begin
					q_data.entry = (own_q == cfsp_pkg::OWN_CLASS) ? 16'd0 : oidx_q;
					q_data.attr = aidx_q;
				end
				if (phase_q inside {cfsp_pkg::K_LONG_LO, cfsp_pkg::K_DOUBLE_LO})
					pnext = {1'b0, pidx_q} + 17'd2;
				case (phase_q)
					cfsp_pkg::K_MAGIC: phase_d = cfsp_pkg::K_MINOR;
					cfsp_pkg::K_MINOR: phase_d = cfsp_pkg::K_MAJOR;
					cfsp_pkg::K_MAJOR: phase_d = cfsp_pkg::K_CPCOUNT;
					cfsp_pkg::K_CPCOUNT: begin
						ptot_d = val[15:0];
						pidx_d = 16'd1;
						phase_d = (val[15:0] > 16'd1) ? cfsp_pkg::K_TAG : cfsp_pkg::K_ACCESS;
					end
					cfsp_pkg::K_TAG: begin
						tag_d = in_byte;
						case (in_byte)
							cfsp_pkg::TAG_UTF8: phase_d = cfsp_pkg::K_UTF8_LEN;
							cfsp_pkg::TAG_INTEGER: phase_d = cfsp_pkg::K_INTEGER;
							cfsp_pkg::TAG_FLOAT: phase_d = cfsp_pkg::K_FLOAT;
							cfsp_pkg::TAG_LONG: phase_d = cfsp_pkg::K_LONG_HI;
							cfsp_pkg::TAG_DOUBLE: phase_d = cfsp_pkg::K_DOUBLE_HI;
							cfsp_pkg::TAG_CLASS: phase_d = cfsp_pkg::K_CLASS_NAME;
							cfsp_pkg::TAG_STRING: phase_d = cfsp_pkg::K_STRING;
							cfsp_pkg::TAG_FIELDREF, cfsp_pkg::TAG_METHODREF,
							cfsp_pkg::TAG_IFMETHODREF: phase_d = cfsp_pkg::K_REF_CLASS;
							cfsp_pkg::TAG_NAT: phase_d = cfsp_pkg::K_NAT_NAME;
							cfsp_pkg::TAG_MHANDLE: phase_d = cfsp_pkg::K_MH_KIND;
							cfsp_pkg::TAG_MTYPE: phase_d = cfsp_pkg::K_MT_DESC;
							cfsp_pkg::TAG_INDY: phase_d = cfsp_pkg::K_INDY_BS;
							cfsp_pkg::TAG_MODULE: phase_d = cfsp_pkg::K_MODULE;
							cfsp_pkg::TAG_PACKAGE: phase_d = cfsp_pkg::K_PACKAGE;
							default: begin
								q_data.err = 1'b1;
								stop_d = 1'b1;
							end
						endcase
					end
					cfsp_pkg::K_UTF8_LEN: begin
						left_d = val;
						if (val == 32'd0) begin
							pidx_d = pnext[15:0];
							phase_d = (pnext < {1'b0, ptot_q}) ? cfsp_pkg::K_TAG
								: cfsp_pkg::K_ACCESS;
						end else phase_d = cfsp_pkg::K_UTF8_BYTE;
					end
					cfsp_pkg::K_UTF8_BYTE: begin
						left_d = lm1;
						if (lm1 == 32'd0) begin
							pidx_d = pnext[15:0];
							phase_d = (pnext < {1'b0, ptot_q}) ? cfsp_pkg::K_TAG
								: cfsp_pkg::K_ACCESS;
						end
					end
					cfsp_pkg::K_LONG_HI: phase_d = cfsp_pkg::K_LONG_LO;
					cfsp_pkg::K_DOUBLE_HI: phase_d = cfsp_pkg::K_DOUBLE_LO;
					cfsp_pkg::K_REF_CLASS: phase_d = cfsp_pkg::K_REF_NAT;
					cfsp_pkg::K_NAT_NAME: phase_d = cfsp_pkg::K_NAT_DESC;
					cfsp_pkg::K_MH_KIND: phase_d = cfsp_pkg::K_MH_INDEX;
					cfsp_pkg::K_INDY_BS: phase_d = cfsp_pkg::K_INDY_NAT;
					cfsp_pkg::K_LONG_LO, cfsp_pkg::K_DOUBLE_LO, cfsp_pkg::K_INTEGER,
					cfsp_pkg::K_FLOAT, cfsp_pkg::K_CLASS_NAME, cfsp_pkg::K_STRING,
					cfsp_pkg::K_REF_NAT, cfsp_pkg::K_NAT_DESC, cfsp_pkg::K_MH_INDEX,
					cfsp_pkg::K_MT_DESC, cfsp_pkg::K_INDY_NAT, cfsp_pkg::K_MODULE,
					cfsp_pkg::K_PACKAGE: begin
						pidx_d = pnext[15:0];
						phase_d = (pnext < {1'b0, ptot_q}) ? cfsp_pkg::K_TAG
							: cfsp_pkg::K_ACCESS;
					end
					cfsp_pkg::K_ACCESS: phase_d = cfsp_pkg::K_THIS;
					cfsp_pkg::K_THIS: phase_d = cfsp_pkg::K_SUPER;
					cfsp_pkg::K_SUPER: phase_d = cfsp_pkg::K_IF_COUNT;
					cfsp_pkg::K_IF_COUNT: begin
						otot_d = val[15:0]; oidx_d = '0;
						phase_d = (val[15:0] == 16'd0) ? cfsp_pkg::K_FIELDS_COUNT
							: cfsp_pkg::K_INTERFACE;
					end
					cfsp_pkg::K_INTERFACE: begin
						oidx_d = onext;
						if (onext >= otot_q) phase_d = cfsp_pkg::K_FIELDS_COUNT;
					end
					cfsp_pkg::K_FIELDS_COUNT: begin
						otot_d = val[15:0]; oidx_d = '0;
						phase_d = (val[15:0] == 16'd0) ? cfsp_pkg::K_METHODS_COUNT
							: cfsp_pkg::K_F_ACCESS;
					end
					cfsp_pkg::K_F_ACCESS: phase_d = cfsp_pkg::K_F_NAME;
					cfsp_pkg::K_F_NAME: phase_d = cfsp_pkg::K_F_DESC;
					cfsp_pkg::K_F_DESC: phase_d = cfsp_pkg::K_F_ACOUNT;
					cfsp_pkg::K_METHODS_COUNT: begin
						otot_d = val[15:0]; oidx_d = '0;
						phase_d = (val[15:0] == 16'd0) ? cfsp_pkg::K_CLASS_ACOUNT
							: cfsp_pkg::K_M_ACCESS;
					end
					cfsp_pkg::K_M_ACCESS: phase_d = cfsp_pkg::K_M_NAME;
					cfsp_pkg::K_M_NAME: phase_d = cfsp_pkg::K_M_DESC;
					cfsp_pkg::K_M_DESC: phase_d = cfsp_pkg::K_M_ACOUNT;
					cfsp_pkg::K_F_ACOUNT, cfsp_pkg::K_M_ACOUNT, cfsp_pkg::K_CLASS_ACOUNT: begin
						atot_d = val[15:0]; aidx_d = '0;
						own_d = (phase_q == cfsp_pkg::K_F_ACOUNT) ? cfsp_pkg::OWN_FIELD :
							(phase_q == cfsp_pkg::K_M_ACOUNT) ? cfsp_pkg::OWN_METHOD
							: cfsp_pkg::OWN_CLASS;
						if (phase_q == cfsp_pkg::K_CLASS_ACOUNT) oidx_d = '0;
						if (val[15:0] != 16'd0) phase_d = cfsp_pkg::K_ATTR_NAME;
						else if (phase_q == cfsp_pkg::K_CLASS_ACOUNT) done = 1'b1;
						else begin
							oidx_d = onext;
							if (onext < otot_q)
								phase_d = (phase_q == cfsp_pkg::K_F_ACOUNT) ?
									cfsp_pkg::K_F_ACCESS : cfsp_pkg::K_M_ACCESS;
							else
								phase_d = (phase_q == cfsp_pkg::K_F_ACOUNT) ?
									cfsp_pkg::K_METHODS_COUNT : cfsp_pkg::K_CLASS_ACOUNT;
						end
					end
					cfsp_pkg::K_ATTR_NAME: phase_d = cfsp_pkg::K_ATTR_LEN;
					cfsp_pkg::K_ATTR_LEN, cfsp_pkg::K_ATTR_BYTE: begin
						left_d = (phase_q == cfsp_pkg::K_ATTR_LEN) ? val : lm1;
						if (phase_q == cfsp_pkg::K_ATTR_LEN && val != 32'd0)
							phase_d = cfsp_pkg::K_ATTR_BYTE;
						else if (left_d == 32'd0) begin
							aidx_d = anext;
							if (anext < atot_q) phase_d = cfsp_pkg::K_ATTR_NAME;
							else if (own_q == cfsp_pkg::OWN_CLASS) done = 1'b1;
							else begin
								oidx_d = onext;
								if (onext < otot_q)
									phase_d = (own_q == cfsp_pkg::OWN_FIELD) ?
										cfsp_pkg::K_F_ACCESS : cfsp_pkg::K_M_ACCESS;
								else
									phase_d = (own_q == cfsp_pkg::OWN_FIELD) ?
										cfsp_pkg::K_METHODS_COUNT : cfsp_pkg::K_CLASS_ACOUNT;
							end
						end else phase_d = cfsp_pkg::K_ATTR_BYTE;
					end
					default: ;
				endcase
				if (done) stop_d = 1'b1;
				q_data.done = done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfsp_pkg::K_MAGIC; cnt_q <= '0; asm_q <= '0; tag_q <= '0;
			pidx_q <= 16'd1; ptot_q <= '0; oidx_q <= '0; otot_q <= '0;
			aidx_q <= '0; atot_q <= '0; left_q <= '0; stop_q <= 1'b0;
			own_q <= cfsp_pkg::OWN_FIELD;
		end else begin
			phase_q <= phase_d; cnt_q <= cnt_d; asm_q <= asm_d; tag_q <= tag_d;
			pidx_q <= pidx_d; ptot_q <= ptot_d; oidx_q <= oidx_d; otot_q <= otot_d;
			aidx_q <= aidx_d; atot_q <= atot_d; left_q <= left_d; stop_q <= stop_d;
			own_q <= own_d;
		end
	end
endmodule
`default_nettype wire

>>> sv/cfsp_queue.sv
`default_nettype none
// Two-entry result queue between the walker and the output port.
module cfsp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cfsp_pkg::res_t din,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cfsp_pkg::res_t     dout
);
	cfsp_pkg::res_t mem_q [cfsp_pkg::QDEPTH];
	logic [cfsp_pkg::QAW-1:0] wp_q, rp_q;
	logic [cfsp_pkg::QAW:0]   cnt_q;
	logic pop;

	assign full = (cnt_q == (cfsp_pkg::QAW+1)'(cfsp_pkg::QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid & out_ready;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end
endmodule
`default_nettype wire

>>> sv/class_file_stream_parser_unit.sv
`default_nettype none
// Byte-serial class file parser: one byte accepted per cycle when the result queue has room.
// Output: a completing byte's result is registered into the result queue on acceptance.
// Throughput: one byte per cycle while the result queue is not full.
// Reset: arst_n clears the walker to the magic field and empties the queue.
module class_file_stream_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       field_kind,
	output logic [31:0]      field_value,
	output logic [7:0]       pool_tag,
	output logic [15:0]      entry_index,
	output logic [15:0]      attribute_index,
	output logic             parse_error,
	output logic             parse_done
);
	logic push, full;
	cfsp_pkg::res_t qin, qout;

	cfsp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte(data_byte),
		.q_push(push), .q_data(qin), .q_full(full)
	);

	cfsp_queue u_queue (
		.clk, .arst_n, .push, .din(qin), .full, .out_valid, .out_ready, .dout(qout)
	);

	assign field_kind = qout.kind;
	assign field_value = qout.value;
	assign pool_tag = qout.tag;
	assign entry_index = qout.entry;
	assign attribute_index = qout.attr;
	assign parse_error = qout.err;
	assign parse_done = qout.done;
endmodule
`default_nettype wire

>>> test/class_file_stream_parser_unit_tb.sv
`timescale 1ns / 1ps
module class_file_stream_parser_unit_tb;
	localparam logic [7:0] T_UTF8 = cfsp_pkg::TAG_UTF8, T_INT = cfsp_pkg::TAG_INTEGER;
	localparam logic [7:0] T_FLOAT = cfsp_pkg::TAG_FLOAT, T_LONG = cfsp_pkg::TAG_LONG;
	localparam logic [7:0] T_DOUBLE = cfsp_pkg::TAG_DOUBLE, T_CLASS = cfsp_pkg::TAG_CLASS;
	localparam logic [7:0] T_STRING = cfsp_pkg::TAG_STRING, T_FREF = cfsp_pkg::TAG_FIELDREF;
	localparam logic [7:0] T_MREF = cfsp_pkg::TAG_METHODREF;
	localparam logic [7:0] T_IMREF = cfsp_pkg::TAG_IFMETHODREF, T_NAT = cfsp_pkg::TAG_NAT;
	localparam logic [7:0] T_MH = cfsp_pkg::TAG_MHANDLE, T_MT = cfsp_pkg::TAG_MTYPE;
	localparam logic [7:0] T_INDY = cfsp_pkg::TAG_INDY, T_MODULE = cfsp_pkg::TAG_MODULE;
	localparam logic [7:0] T_PACKAGE = cfsp_pkg::TAG_PACKAGE;
	localparam int IDLE_LIMIT = 5000;
	localparam int MODE_ERROR = 0, MODE_TINY_POOL = 1, MODE_FULL = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] field_kind;
	logic [31:0] field_value;
	logic [7:0] pool_tag;
	logic [15:0] entry_index;
	logic [15:0] attribute_index;
	logic parse_error;
	logic parse_done;

	class_file_stream_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.field_kind(field_kind), .field_value(field_value), .pool_tag(pool_tag),
		.entry_index(entry_index), .attribute_index(attribute_index),
		.parse_error(parse_error), .parse_done(parse_done)
	);

	initial forever #1 clk = ~clk;

	// parser state mirror
	cfsp_pkg::kind_t  ph;
	logic [2:0]  nbytes;
	logic [31:0] acc;
	logic [7:0]  tag_r;
	logic [15:0] pidx, ptot, oidx, otot, aidx, atot;
	logic [31:0] left;
	bit          halted;
	cfsp_pkg::owner_t owner;

	cfsp_pkg::res_t field_q[$];
	logic [7:0] file_q[$];
	int n_mismatch = 0;
	int n_fields = 0;
	int n_bytes = 0;
	int file_mode;
	bit saw_err = 0, saw_done = 0;

	function automatic int field_len(cfsp_pkg::kind_t k);
		case (k)
			cfsp_pkg::K_MAGIC, cfsp_pkg::K_INTEGER, cfsp_pkg::K_FLOAT, cfsp_pkg::K_LONG_HI,
			cfsp_pkg::K_LONG_LO, cfsp_pkg::K_DOUBLE_HI, cfsp_pkg::K_DOUBLE_LO,
			cfsp_pkg::K_ATTR_LEN: return 4;
			cfsp_pkg::K_TAG, cfsp_pkg::K_UTF8_BYTE, cfsp_pkg::K_MH_KIND,
			cfsp_pkg::K_ATTR_BYTE: return 1;
			default: return 2;
		endcase
	endfunction

	function automatic bit known_tag(logic [7:0] t);
		case (t)
			T_UTF8, T_INT, T_FLOAT, T_LONG, T_DOUBLE, T_CLASS, T_STRING, T_FREF, T_MREF,
			T_IMREF, T_NAT, T_MH, T_MT, T_INDY, T_MODULE, T_PACKAGE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit owner_done();
		if (owner == cfsp_pkg::OWN_CLASS)
			return 1'b1;
		oidx = oidx + 16'd1;
		if (oidx < otot)
			ph = (owner == cfsp_pkg::OWN_FIELD) ? cfsp_pkg::K_F_ACCESS : cfsp_pkg::K_M_ACCESS;
		else if (owner == cfsp_pkg::OWN_FIELD)
			ph = cfsp_pkg::K_METHODS_COUNT;
		else
			ph = cfsp_pkg::K_CLASS_ACOUNT;
		return 1'b0;
	endfunction

	function automatic bit open_attrs(logic [15:0] n, cfsp_pkg::owner_t o);
		atot = n;
		aidx = 16'd0;
		owner = o;
		if (n == 16'd0)
			return owner_done();
		ph = cfsp_pkg::K_ATTR_NAME;
		return 1'b0;
	endfunction

	function automatic bit next_attr();
		aidx = aidx + 16'd1;
		if (aidx < atot) begin
			ph = cfsp_pkg::K_ATTR_NAME;
			return 1'b0;
		end
		return owner_done();
	endfunction

	function automatic void pool_next(int slots);
		logic [16:0] nx;
		nx = {1'b0, pidx} + 17'(slots);
		pidx = nx[15:0];
		ph = (nx < {1'b0, ptot}) ? cfsp_pkg::K_TAG : cfsp_pkg::K_ACCESS;
	endfunction

	function automatic void parser_reset();
		ph = cfsp_pkg::K_MAGIC;
		nbytes = 3'd0;
		acc = 32'd0;
		tag_r = 8'd0;
		pidx = 16'd1;
		ptot = 16'd0;
		oidx = 16'd0;
		otot = 16'd0;
		aidx = 16'd0;
		atot = 16'd0;
		left = 32'd0;
		halted = 1'b0;
		owner = cfsp_pkg::OWN_FIELD;
	endfunction

	// advance the mirror by one byte; got is set when a field completes
	function automatic void parse_byte(input logic [7:0] b, output bit got,
		output cfsp_pkg::res_t r);
		logic [31:0] val;
		cfsp_pkg::kind_t k;
		bit fin;
		got = 1'b0;
		r = '0;
		fin = 1'b0;
		if (halted)
			return;
		acc = {acc[23:0], b};
		nbytes = nbytes + 3'd1;
		if (int'(nbytes) < field_len(ph))
			return;
		val = acc;
		acc = 32'd0;
		nbytes = 3'd0;
		k = ph;
		got = 1'b1;
		if (k == cfsp_pkg::K_TAG)
			tag_r = val[7:0];
		if (k >= cfsp_pkg::K_TAG && k <= cfsp_pkg::K_PACKAGE) begin
			r.tag = tag_r;
			r.entry = pidx;
		end else if (k == cfsp_pkg::K_INTERFACE ||
				(k >= cfsp_pkg::K_F_ACCESS && k <= cfsp_pkg::K_F_ACOUNT) ||
				(k >= cfsp_pkg::K_M_ACCESS && k <= cfsp_pkg::K_M_ACOUNT)) begin
			r.entry = oidx;
		end else if (k >= cfsp_pkg::K_ATTR_NAME) begin
			r.entry = (owner == cfsp_pkg::OWN_CLASS) ? 16'd0 : oidx;
			r.attr = aidx;
		end
		case (k)
			cfsp_pkg::K_MAGIC: ph = cfsp_pkg::K_MINOR;
			cfsp_pkg::K_MINOR: ph = cfsp_pkg::K_MAJOR;
			cfsp_pkg::K_MAJOR: ph = cfsp_pkg::K_CPCOUNT;
			cfsp_pkg::K_CPCOUNT: begin
				ptot = val[15:0];
				pidx = 16'd1;
				ph = (pidx < ptot) ? cfsp_pkg::K_TAG : cfsp_pkg::K_ACCESS;
			end
			cfsp_pkg::K_TAG: begin
				case (tag_r)
					T_UTF8: ph = cfsp_pkg::K_UTF8_LEN;
					T_INT: ph = cfsp_pkg::K_INTEGER;
					T_FLOAT: ph = cfsp_pkg::K_FLOAT;
					T_LONG: ph = cfsp_pkg::K_LONG_HI;
					T_DOUBLE: ph = cfsp_pkg::K_DOUBLE_HI;
					T_CLASS: ph = cfsp_pkg::K_CLASS_NAME;
					T_STRING: ph = cfsp_pkg::K_STRING;
					T_FREF, T_MREF, T_IMREF: ph = cfsp_pkg::K_REF_CLASS;
					T_NAT: ph = cfsp_pkg::K_NAT_NAME;
					T_MH: ph = cfsp_pkg::K_MH_KIND;
					T_MT: ph = cfsp_pkg::K_MT_DESC;
					T_INDY: ph = cfsp_pkg::K_INDY_BS;
					T_MODULE: ph = cfsp_pkg::K_MODULE;
					T_PACKAGE: ph = cfsp_pkg::K_PACKAGE;
					default: begin
						r.err = 1'b1;
						halted = 1'b1;
					end
				endcase
			end
			cfsp_pkg::K_UTF8_LEN: begin
				left = val;
				if (left == 32'd0) pool_next(1); else ph = cfsp_pkg::K_UTF8_BYTE;
			end
			cfsp_pkg::K_UTF8_BYTE: begin
				left = left - 32'd1;
				if (left == 32'd0) pool_next(1);
			end
			cfsp_pkg::K_LONG_HI: ph = cfsp_pkg::K_LONG_LO;
			cfsp_pkg::K_DOUBLE_HI: ph = cfsp_pkg::K_DOUBLE_LO;
			cfsp_pkg::K_LONG_LO, cfsp_pkg::K_DOUBLE_LO: pool_next(2);
			cfsp_pkg::K_REF_CLASS: ph = cfsp_pkg::K_REF_NAT;
			cfsp_pkg::K_NAT_NAME: ph = cfsp_pkg::K_NAT_DESC;
			cfsp_pkg::K_MH_KIND: ph = cfsp_pkg::K_MH_INDEX;
			cfsp_pkg::K_INDY_BS: ph = cfsp_pkg::K_INDY_NAT;
			cfsp_pkg::K_INTEGER, cfsp_pkg::K_FLOAT, cfsp_pkg::K_CLASS_NAME,
			cfsp_pkg::K_STRING, cfsp_pkg::K_REF_NAT, cfsp_pkg::K_NAT_DESC,
			cfsp_pkg::K_MH_INDEX, cfsp_pkg::K_MT_DESC, cfsp_pkg::K_INDY_NAT,
			cfsp_pkg::K_MODULE, cfsp_pkg::K_PACKAGE: pool_next(1);
			cfsp_pkg::K_ACCESS: ph = cfsp_pkg::K_THIS;
			cfsp_pkg::K_THIS: ph = cfsp_pkg::K_SUPER;
			cfsp_pkg::K_SUPER: ph = cfsp_pkg::K_IF_COUNT;
			cfsp_pkg::K_IF_COUNT: begin
				otot = val[15:0];
				oidx = 16'd0;
				ph = (otot == 16'd0) ? cfsp_pkg::K_FIELDS_COUNT : cfsp_pkg::K_INTERFACE;
			end
			cfsp_pkg::K_INTERFACE: begin
				oidx = oidx + 16'd1;
				if (oidx >= otot) ph = cfsp_pkg::K_FIELDS_COUNT;
			end
			cfsp_pkg::K_FIELDS_COUNT: begin
				otot = val[15:0];
				oidx = 16'd0;
				ph = (otot == 16'd0) ? cfsp_pkg::K_METHODS_COUNT : cfsp_pkg::K_F_ACCESS;
			end
			cfsp_pkg::K_F_ACCESS: ph = cfsp_pkg::K_F_NAME;
			cfsp_pkg::K_F_NAME: ph = cfsp_pkg::K_F_DESC;
			cfsp_pkg::K_F_DESC: ph = cfsp_pkg::K_F_ACOUNT;
			cfsp_pkg::K_F_ACOUNT: fin = open_attrs(val[15:0], cfsp_pkg::OWN_FIELD);
			cfsp_pkg::K_METHODS_COUNT: begin
				otot = val[15:0];
				oidx = 16'd0;
				ph = (otot == 16'd0) ? cfsp_pkg::K_CLASS_ACOUNT : cfsp_pkg::K_M_ACCESS;
			end
			cfsp_pkg::K_M_ACCESS: ph = cfsp_pkg::K_M_NAME;
			cfsp_pkg::K_M_NAME: ph = cfsp_pkg::K_M_DESC;
			cfsp_pkg::K_M_DESC: ph = cfsp_pkg::K_M_ACOUNT;
			cfsp_pkg::K_M_ACOUNT: fin = open_attrs(val[15:0], cfsp_pkg::OWN_METHOD);
			cfsp_pkg::K_CLASS_ACOUNT: begin
				oidx = 16'd0;
				fin = open_attrs(val[15:0], cfsp_pkg::OWN_CLASS);
			end
			cfsp_pkg::K_ATTR_NAME: ph = cfsp_pkg::K_ATTR_LEN;
			cfsp_pkg::K_ATTR_LEN: begin
				left = val;
				if (left == 32'd0) fin = next_attr(); else ph = cfsp_pkg::K_ATTR_BYTE;
			end
			default: begin
				left = left - 32'd1;
				if (left == 32'd0) fin = next_attr();
			end
		endcase
		if (fin)
			halted = 1'b1;
		r.kind = k;
		r.value = val;
		r.done = fin;
	endfunction

	// file builders
	function automatic void put16(ref logic [7:0] q[$], input logic [15:0] v);
		q.push_back(v[15:8]);
		q.push_back(v[7:0]);
	endfunction

	function automatic void put32(ref logic [7:0] q[$], input logic [31:0] v);
		put16(q, v[31:16]);
		put16(q, v[15:0]);
	endfunction

	function automatic logic [15:0] rnd16();
		return (($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
	endfunction

	function automatic void put_attrs(int n);
		int len;
		for (int a = 0; a < n; a++) begin
			put16(file_q, rnd16());
			len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			put32(file_q, 32'(len));
			for (int j = 0; j < len; j++)
				file_q.push_back(8'($urandom));
		end
	endfunction

	function automatic void put_members(int n);
		int na;
		put16(file_q, 16'(n));
		for (int m = 0; m < n; m++) begin
			put16(file_q, rnd16());
			put16(file_q, rnd16());
			put16(file_q, rnd16());
			na = $urandom_range(0, 2);
			put16(file_q, 16'(na));
			put_attrs(na);
		end
	endfunction

	function automatic void put_entry(ref logic [7:0] q[$], input logic [7:0] t, inout int slot);
		int len;
		q.push_back(t);
		slot++;
		case (t)
			T_UTF8: begin
				len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
				put16(q, 16'(len));
				for (int j = 0; j < len; j++)
					q.push_back(8'($urandom));
			end
			T_INT, T_FLOAT: put32(q, $urandom);
			T_LONG, T_DOUBLE: begin
				put32(q, $urandom);
				put32(q, $urandom);
				slot++;
			end
			T_CLASS, T_STRING, T_MT, T_MODULE, T_PACKAGE: put16(q, rnd16());
			T_MH: begin
				q.push_back(8'($urandom));
				put16(q, rnd16());
			end
			default: begin
				put16(q, rnd16());
				put16(q, rnd16());
			end
		endcase
	endfunction

	function automatic logic [7:0] any_known_tag();
		logic [7:0] t;
		do t = 8'($urandom_range(0, 20)); while (!known_tag(t));
		return t;
	endfunction

	// body of the file after the fixed header rows
	function automatic void build_body();
		logic [7:0] pool_q[$];
		logic [7:0] all_tags[16];
		logic [7:0] bad;
		int slot;
		all_tags = '{T_UTF8, T_INT, T_FLOAT, T_LONG, T_DOUBLE, T_CLASS, T_STRING, T_FREF,
			T_MREF, T_IMREF, T_NAT, T_MH, T_MT, T_INDY, T_MODULE, T_PACKAGE};
		slot = 1;
		if (file_mode == MODE_TINY_POOL) begin
			put16(file_q, 16'($urandom_range(0, 1)));
		end else begin
			foreach (all_tags[i])
				put_entry(pool_q, all_tags[i], slot);
			while (pool_q.size() < 560)
				put_entry(pool_q, any_known_tag(), slot);
			// optionally a two-slot entry in the last slot
			if ($urandom_range(0, 1))
				put_entry(pool_q, T_LONG, slot);
			if (file_mode == MODE_ERROR) begin
				do bad = 8'($urandom); while (known_tag(bad));
				pool_q.push_back(bad);
				put16(file_q, 16'(slot + 1 + $urandom_range(0, 3)));
			end else begin
				put16(file_q, 16'(slot));
			end
			foreach (pool_q[i])
				file_q.push_back(pool_q[i]);
		end
		if (file_mode != MODE_ERROR) begin
			put16(file_q, rnd16());
			put16(file_q, rnd16());
			put16(file_q, rnd16());
			put16(file_q, 16'($urandom_range(0, 4)));
			repeat (file_q[file_q.size() - 1]) put16(file_q, rnd16());
			put_members($urandom_range(0, 4));
			put_members($urandom_range(0, 4));
			put16(file_q, 16'($urandom_range(0, 3)));
			put_attrs(file_q[file_q.size() - 1]);
		end
		// trailing bytes after the parser stops, padded out to a full-size run
		repeat (8) file_q.push_back(8'($urandom));
		while (file_q.size() < 800)
			file_q.push_back(8'($urandom));
	endfunction

	// header rows, typed expectations where a field completes
	typedef struct {
		logic [7:0]       b;
		bit               chk;
		cfsp_pkg::kind_t  k;
		logic [31:0]      v;
	} row_t;

	row_t hdr_rows[8] = '{
		'{8'hCA, 0, cfsp_pkg::K_MAGIC, 32'h0}, '{8'hFE, 0, cfsp_pkg::K_MAGIC, 32'h0},
		'{8'hBA, 0, cfsp_pkg::K_MAGIC, 32'h0}, '{8'hBE, 1, cfsp_pkg::K_MAGIC, 32'hCAFEBABE},
		'{8'h00, 0, cfsp_pkg::K_MINOR, 32'h0}, '{8'h00, 1, cfsp_pkg::K_MINOR, 32'h0},
		'{8'hFF, 0, cfsp_pkg::K_MAJOR, 32'h0}, '{8'hFF, 1, cfsp_pkg::K_MAJOR, 32'hFFFF}
	};

	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// result checker and stall generator
	int stall_left = 0;
	int rx_count = 0;
	always @(posedge clk) begin
		cfsp_pkg::res_t got_r, want;
		if (out_valid && out_ready) begin
			got_r = '{field_kind, field_value, pool_tag, entry_index, attribute_index,
				parse_error, parse_done};
			n_fields++;
			if (parse_error) saw_err = 1'b1;
			if (parse_done) saw_done = 1'b1;
			if (field_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected field: kind %0d value %h", field_kind, field_value);
			end else begin
				want = field_q.pop_front();
				if (got_r !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("mismatch: exp kind %0d val %h tag %0d ent %0d att %0d err %b done %b",
							want.kind, want.value, want.tag, want.entry, want.attr,
							want.err, want.done);
						$display("          got kind %0d val %h tag %0d ent %0d att %0d err %b done %b",
							got_r.kind, got_r.value, got_r.tag, got_r.entry, got_r.attr,
							got_r.err, got_r.done);
					end
				end
			end
		end
		rx_count++;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ((rx_count / 200) % 3 == 1) begin
			out_ready <= 1'b1;
		end else begin
			stall_left = pick_gap(1'b0);
			out_ready <= (stall_left == 0);
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d fields still awaited", field_q.size());
			$display("FAIL class_file_stream_parser_unit");
			$finish;
		end
	end

	initial begin
		bit got, burst;
		cfsp_pkg::res_t r;
		int gap;
		int n;
		parser_reset();
		case ($urandom_range(0, 5))
			0: file_mode = MODE_ERROR;
			1: file_mode = MODE_TINY_POOL;
			default: file_mode = MODE_FULL;
		endcase
		foreach (hdr_rows[i])
			file_q.push_back(hdr_rows[i].b);
		build_body();
		n = file_q.size();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = pick_gap(burst);
			if (i == n / 2) begin
				// hold off until the checker has caught up
				in_valid <= 1'b0;
				do @(posedge clk); while (field_q.size() != 0);
				gap = 0;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= file_q[i];
			do @(posedge clk); while (!in_ready);
			n_bytes++;
			parse_byte(file_q[i], got, r);
			if (got) begin
				if (i < 8 && hdr_rows[i].chk)
					r = '{hdr_rows[i].k, hdr_rows[i].v, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0};
				field_q.push_back(r);
			end
		end
		in_valid <= 1'b0;
		while (field_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d bytes, checked %0d fields (file shape %0d)",
			n_bytes, n_fields, file_mode);
		$display("unknown tag seen %0b, end of file seen %0b, mismatches %0d",
			saw_err, saw_done, n_mismatch);
		if (n_mismatch == 0 && field_q.size() == 0)
			$display("PASS class_file_stream_parser_unit");
		else
			$display("FAIL class_file_stream_parser_unit");
		$finish;
	end
endmodule
